// ===== rtl/utf8d_pkg.sv =====
package utf8d_pkg;

  // default width of the per-string character counter
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 16;

  // limit register reset value
  localparam logic [15:0] MAX_CHARS_RESET = 16'hFFFF;

  // replacement character for a byte that cannot start a form
  localparam logic [CP_W-1:0] BAD_CHAR = 16'hFFFD;

  // lead byte patterns
  localparam logic [BYTE_W-1:0] ASCII_TOP  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
  localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3F;

  // what a byte means when no form is in progress
  typedef enum logic [2:0] {
    KIND_END,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_BAD
  } byte_kind_t;

  // form in progress
  typedef struct packed {
    logic [1:0]      pending;
    logic [CP_W-1:0] partial;
  } form_state_t;

  // one result of a byte
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] code_point;
    logic            string_end;
    logic [15:0]     char_total;
  } result_t;

  function automatic byte_kind_t classify(input logic [BYTE_W-1:0] b);
    byte_kind_t k;
    if (b == '0) begin
      k = KIND_END;
    end else if (b < ASCII_TOP) begin
      k = KIND_ASCII;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      k = KIND_LEAD2;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      k = KIND_LEAD3;
    end else begin
      k = KIND_BAD;
    end
    return k;
  endfunction

endpackage

// ===== rtl/utf8_decoder_three_byte.sv =====
// UTF-8 decoder for forms of up to three bytes, giving 16-bit code points.
// Slave side (s_tvalid, s_tready, s_tdata) takes one raw byte per request;
// a zero byte ends the string. Master side (m_tvalid, m_tready, m_tdata,
// m_tuser) returns at most one result per byte: a code point, or with
// m_tuser high an end-of-string report carrying the character count.
// Bytes that only start or continue a form give no result.
// The cfg channel writes the per-string character limit; cfg_ready is
// always high. Write it only while no byte is in flight.
// A byte accepted into the input register is decoded into the result
// register, from which its result, if any, is shown.
// Throughput: one byte per cycle unless the receiver stalls. An input
// register and a result register sit on either side of a single decode
// step that updates the form state and the character counter.
// Reset clears the form state, the counter and both valid flags and sets
// the limit to 65535.
// When the receiver stalls, the result register holds, the input register
// then fills and s_tready drops until m_tready returns.
module utf8_decoder_three_byte import utf8d_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] code_point, [31:16] char_total
  output logic        m_tuser,   // [0] string_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic                  in_valid;
  logic [BYTE_W-1:0]     in_byte;
  logic                  adv;
  logic [15:0]           max_chars;
  form_state_t           form;
  form_state_t           form_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  result_t               res;
  logic                  out_valid;
  logic [CP_W-1:0]       out_cp;
  logic                  out_end;
  logic [15:0]           out_total;

  // input register moves on when the result register is free or drained
  assign adv       = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || adv;
  assign cfg_ready = 1'b1;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_chars <= cfg_data;
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  utf8d_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .in_byte    (in_byte),
    .max_chars  (max_chars),
    .form       (form),
    .count      (count),
    .form_next  (form_next),
    .count_next (count_next),
    .res        (res)
  );

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      form  <= '0;
      count <= '0;
    end else if (adv) begin
      form  <= form_next;
      count <= count_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res.valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_cp    <= res.code_point;
      out_end   <= res.string_end;
      out_total <= res.char_total;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_total, out_cp};
  assign m_tuser  = out_end;

endmodule

// ===== rtl/utf8d_step.sv =====
module utf8d_step import utf8d_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic [15:0]           max_chars,
  input  form_state_t           form,
  input  logic [COUNT_BITS-1:0] count,
  output form_state_t           form_next,
  output logic [COUNT_BITS-1:0] count_next,
  output result_t               res
);

  localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [LW-1:0]     count_w;
  logic [LW-1:0]     max_w;
  logic [LW-1:0]     mask_w;
  logic [LW-1:0]     limit_w;
  logic              full;
  byte_kind_t        kind;
  logic [CP_W-1:0]   cont_bits;
  logic [CP_W-1:0]   gathered;
  logic [1:0]        pend_dec;
  logic [BYTE_W-1:0] lead2_bits;
  logic [BYTE_W-1:0] lead3_bits;

  // limit capped at what the counter can hold
  assign count_w = LW'(count);
  assign max_w   = LW'(max_chars);
  assign mask_w  = LW'({COUNT_BITS{1'b1}});
  assign limit_w = (max_w > mask_w) ? mask_w : max_w;
  assign full    = (count_w >= limit_w);

  assign kind = classify(in_byte);

  // continuation bits shifted into place
  assign cont_bits  = CP_W'(in_byte & CONT_DATA);
  assign gathered   = form.partial | ((form.pending == 2'd2) ? (cont_bits << 6) : cont_bits);
  assign pend_dec   = form.pending - 2'd1;
  assign lead2_bits = in_byte & LEAD2_DATA;
  assign lead3_bits = in_byte & LEAD3_DATA;

  // next state and result
  always_comb begin
    form_next = form;
    count_next = count;
    res = '0;
    if (kind == KIND_END) begin
      res.valid      = 1'b1;
      res.string_end = 1'b1;
      res.char_total = count_w[15:0];
      form_next      = '0;
      count_next     = '0;
    end else if (form.pending != 2'd0) begin
      form_next.pending = pend_dec;
      form_next.partial = gathered;
      if (pend_dec == 2'd0) begin
        count_next        = count + 1'b1;
        res.valid         = 1'b1;
        res.code_point    = gathered;
        form_next.partial = '0;
      end
    end else if (!full) begin
      unique case (kind)
        KIND_ASCII: begin
          count_next     = count + 1'b1;
          res.valid      = 1'b1;
          res.code_point = CP_W'(in_byte);
        end
        KIND_LEAD2: begin
          form_next.partial = CP_W'(lead2_bits) << 6;
          form_next.pending = 2'd1;
        end
        KIND_LEAD3: begin
          form_next.partial = CP_W'(lead3_bits) << 12;
          form_next.pending = 2'd2;
        end
        KIND_BAD: begin
          count_next     = count + 1'b1;
          res.valid      = 1'b1;
          res.code_point = BAD_CHAR;
        end
        default: begin
          form_next = form;
        end
      endcase
    end
  end

endmodule

// ===== rtl/utf8d_checker.sv =====
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // character results carry no count
  a_char_no_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'h0000)
    else $error("character result with nonzero count");

  // end report carries a zero code point
  a_end_no_cp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0000)
    else $error("end report with nonzero code point");

  // nothing is shown straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown after reset");

endmodule

bind utf8_decoder_three_byte utf8d_checker u_chk (.*);
